// ===== hdl/rtiu_pkg.sv =====
// Shared types, register offsets and timing constants for the raster timing unit.
// No dependencies; imported by the top level, rtiu_core and the bench (rtiu_ram does not use it).
`timescale 1ns / 1ps

package rtiu_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_READ    = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STALL_NONE = 2'd0,
        STALL_READ = 2'd1,
        STALL_FULL = 2'd2
    } stall_t;

    // configuration register indexes
    localparam logic CFG_NTSC = 1'b0;
    localparam logic CFG_RSID = 1'b1;

    localparam int REG_SLOTS_DEF = 64;

    localparam logic [5:0] OFF_CONTROL = 6'h11;
    localparam logic [5:0] OFF_RASTER  = 6'h12;
    localparam logic [5:0] OFF_STATUS  = 6'h19;
    localparam logic [5:0] OFF_ENABLE  = 6'h1A;

    localparam logic [6:0] PAL_CYCLES   = 7'd63;
    localparam logic [6:0] NTSC_CYCLES  = 7'd65;
    localparam logic [8:0] PAL_LINES    = 9'd312;
    localparam logic [8:0] NTSC_LINES   = 9'd263;

    localparam logic [7:0] CTRL_DEF      = 8'h1B;
    localparam logic [7:0] CTRL_RSID     = 8'h9B;
    localparam logic [7:0] CMP_DEF       = 8'h00;
    localparam logic [7:0] CMP_RSID      = 8'h37;
    localparam logic [7:0] STATUS_DEF    = 8'h01;
    localparam logic [7:0] ENABLE_DEF    = 8'h00;

    // bad-line window
    localparam logic [8:0] BAD_FIRST     = 9'h030;
    localparam logic [8:0] BAD_LAST      = 9'h0F7;
    localparam logic [6:0] STALL_START   = 7'd11;
    localparam logic [6:0] STALL_FULL_AT = 7'd14;
    localparam logic [6:0] STALL_END     = 7'd53;

    // one result as it leaves the register stage
    typedef struct packed {
        logic [7:0] rd_data;   // register byte, unless taken from the slot RAM
        logic       mem_rd;    // read data comes from the slot RAM
        logic       irq;
        stall_t     stall;
        logic [8:0] line;
    } rtiu_res_t;

endpackage

// ===== hdl/raster_timing_irq_unit.sv =====
// Top level of the raster timing and interrupt unit: request pipeline,
// slot RAM with valid bits, output register. Depends on rtiu_pkg, rtiu_core, rtiu_ram.
`timescale 1ns / 1ps
//
//  channel  | signals                     | contents
//  ---------+-----------------------------+-----------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata   | request: tuser = action, tdata = offset, data
//           | s_tuser                     |
//  m_axis   | m_tvalid m_tready m_tdata   | result: read data, irq, stall level, line
//  cfg      | cfg_we cfg_addr cfg_wdata   | 0 = NTSC geometry, 1 = restart defaults
//
//  One request per cycle sustained while m_tready is high; each result passes the
//  register stage (alongside the registered slot RAM read), then the output register.
//  Reset: counters at the end of the PAL frame, slot bytes read as zero through
//  per-slot valid bits, so no clearing pass is needed.
//  A stalled output holds the result; the request side keeps taking one more request
//  into the register stage before tready falls.

module raster_timing_irq_unit
    import rtiu_pkg::*;
#(
    parameter int REG_SLOTS = REG_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] reg_offset, [13:6] write_data, [15:14] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_data, [8] irq_line, [10:9] cpu_stall,
                                   // [19:11] raster_line, [23:20] zero
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic        cfg_wdata
);

    localparam int SLOT_W = $clog2(REG_SLOTS);

    logic              ntsc_reg;
    logic              rsid_reg;
    logic              accept;
    logic              move;
    logic              mem_wr;
    rtiu_res_t         res;
    action_t           action;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        ram_q;

    logic [REG_SLOTS-1:0] slot_vld_reg, slot_vld_next;
    logic                 s1_valid_reg;
    rtiu_res_t            s1_reg;
    logic                 s1_vld_reg;
    logic                 out_valid_reg;
    logic [23:0]          out_data_reg;
    logic [7:0]           s1_rd;

    assign action   = action_t'(s_tuser);
    assign slot     = s_tdata[SLOT_W-1:0];
    assign move     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || move;
    assign accept   = s_tvalid && s_tready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntsc_reg <= 1'b0;
            rsid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_NTSC: ntsc_reg <= cfg_wdata;
                CFG_RSID: rsid_reg <= cfg_wdata;
                default:  ntsc_reg <= ntsc_reg;
            endcase
        end
    end

    rtiu_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .action (action),
        .offset (s_tdata[5:0]),
        .wdata  (s_tdata[13:6]),
        .ntsc   (ntsc_reg),
        .rsid   (rsid_reg),
        .mem_wr (mem_wr),
        .res    (res)
    );

    rtiu_ram #(
        .WIDTH (8),
        .DEPTH (REG_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (mem_wr),
        .waddr (slot),
        .wdata (s_tdata[13:6]),
        .re    (accept && res.mem_rd),
        .raddr (slot),
        .rdata (ram_q)
    );

    // a slot never written reads as zero
    always_comb
    begin
        slot_vld_next = slot_vld_reg;
        if (mem_wr)
        begin
            slot_vld_next[slot] = 1'b1;
        end
    end

    assign s1_rd = s1_reg.mem_rd ? (s1_vld_reg ? ram_q : 8'd0) : s1_reg.rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_vld_reg <= slot_vld_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg     <= res;
            s1_vld_reg <= slot_vld_reg[slot];
        end
        if (move)
        begin
            out_data_reg <= {4'd0, s1_reg.line, s1_reg.stall, s1_reg.irq, s1_rd};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a held register-stage entry must block the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !move) |-> !s_tready)
        else $error("request taken while register stage is held");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:11] < PAL_LINES) && (m_tdata[10:9] != 2'd3))
        else $error("raster line or stall level out of range");

    // a stalled output must hold both its result and the register-stage entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |=> (s1_valid_reg && out_valid_reg))
        else $error("pipeline lost a result under stall");
`endif

endmodule

// ===== hdl/rtiu_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rtiu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rtiu_core.sv =====
// Beam counters, interrupt registers and control registers; computes each result.
// Depends on rtiu_pkg.
`timescale 1ns / 1ps

module rtiu_core
    import rtiu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  action_t    action,
    input  logic [5:0] offset,
    input  logic [7:0] wdata,
    input  logic       ntsc,
    input  logic       rsid,
    output logic       mem_wr,
    output rtiu_res_t  res
);

    logic [6:0] cyc_reg, cyc_next;
    logic [8:0] line_reg, line_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] cmp_reg, cmp_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] enable_reg, enable_next;

    logic [6:0] cpl;
    logic [8:0] lps;
    logic [8:0] target;
    logic [6:0] cyc_inc;
    logic [8:0] line_inc;
    logic [8:0] line_wrap;
    logic       wrap;
    logic       hit;
    logic [7:0] ack;
    logic       bad_line;
    logic [7:0] rd_data;
    logic       mem_rd;
    stall_t     stall;

    assign cpl      = ntsc ? NTSC_CYCLES : PAL_CYCLES;
    assign lps      = ntsc ? NTSC_LINES : PAL_LINES;
    assign target   = {ctrl_reg[7], cmp_reg};
    assign cyc_inc  = cyc_reg + 7'd1;
    assign line_inc = line_reg + 9'd1;
    assign wrap     = (cyc_inc >= cpl);
    assign line_wrap = (line_inc >= lps) ? 9'd0 : line_inc;
    // line 0 is tested as the beam enters cycle 1, every other line as it enters cycle 0
    assign hit = ((cyc_reg == 7'd0) && (line_reg == 9'd0) && (target == 9'd0))
               || (wrap && (line_wrap != 9'd0) && (line_wrap == target));

    always_comb
    begin
        cyc_next    = cyc_reg;
        line_next   = line_reg;
        ctrl_next   = ctrl_reg;
        cmp_next    = cmp_reg;
        status_next = status_reg;
        enable_next = enable_reg;
        ack         = status_reg & ~wdata;
        mem_wr      = 1'b0;
        rd_data     = '0;
        mem_rd      = 1'b0;
        unique case (action)
            ACT_TICK:
            begin
                cyc_next  = wrap ? 7'd0 : cyc_inc;
                line_next = wrap ? line_wrap : line_reg;
                if (hit)
                begin
                    status_next = status_reg | {enable_reg[0], 6'd0, 1'b1};
                end
            end
            ACT_WRITE:
            begin
                unique case (offset)
                    OFF_CONTROL: ctrl_next = wdata;
                    OFF_RASTER:  cmp_next = wdata;
                    OFF_STATUS:
                    begin
                        // interrupt drops once no source remains
                        status_next = (ack[3:0] == 4'd0) ? {1'b0, ack[6:0]} : ack;
                    end
                    OFF_ENABLE:
                    begin
                        enable_next = wdata;
                        if (wdata[0] && status_reg[0])
                        begin
                            status_next = status_reg | 8'h80;
                        end
                    end
                    default: mem_wr = step;
                endcase
            end
            ACT_READ:
            begin
                unique case (offset)
                    OFF_CONTROL: rd_data = {line_reg[8], ctrl_reg[6:0]};
                    OFF_RASTER:  rd_data = line_reg[7:0];
                    OFF_STATUS:  rd_data = status_reg;
                    OFF_ENABLE:  rd_data = enable_reg;
                    default:     mem_rd = 1'b1;
                endcase
            end
            ACT_RESTART:
            begin
                cyc_next    = cpl - 7'd1;
                line_next   = lps - 9'd1;
                status_next = STATUS_DEF;
                enable_next = ENABLE_DEF;
                ctrl_next   = rsid ? CTRL_RSID : CTRL_DEF;
                cmp_next    = rsid ? CMP_RSID : CMP_DEF;
            end
            default:
            begin
                cyc_next = cyc_reg;
            end
        endcase
    end

    assign bad_line = ctrl_next[4] && (line_next >= BAD_FIRST) && (line_next <= BAD_LAST)
                   && (ctrl_next[2:0] == line_next[2:0]);

    always_comb
    begin
        stall = STALL_NONE;
        if (bad_line && (cyc_next >= STALL_START) && (cyc_next <= STALL_END))
        begin
            stall = (cyc_next >= STALL_FULL_AT) ? STALL_FULL : STALL_READ;
        end
    end

    assign res = '{rd_data, mem_rd, status_next[7], stall, line_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc_reg    <= PAL_CYCLES - 7'd1;
            line_reg   <= PAL_LINES - 9'd1;
            ctrl_reg   <= CTRL_DEF;
            cmp_reg    <= CMP_DEF;
            status_reg <= STATUS_DEF;
            enable_reg <= ENABLE_DEF;
        end
        else if (step)
        begin
            cyc_reg    <= cyc_next;
            line_reg   <= line_next;
            ctrl_reg   <= ctrl_next;
            cmp_reg    <= cmp_next;
            status_reg <= status_next;
            enable_reg <= enable_next;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for raster_timing_irq_unit: a directed table, two short tick sweeps and
// random requests, each result compared with its typed row or a beam and interrupt predictor.
// Depends on rtiu_pkg and the block's RTL only.

module tb_top;
    import rtiu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 6;
    localparam int HOLD_LEN    = 80;
    localparam int HOLD_AT_A   = 150;    // both fall inside the zero-gap sweeps
    localparam int HOLD_AT_B   = 520;
    localparam int SWEEP_PAL   = 400;    // a handful of PAL lines of ticks
    localparam int SWEEP_NTSC  = 200;
    localparam int RAND_PHASE  = 105;
    localparam int DIR_ROWS    = 26;

    // geometry and restart values for the predictor
    localparam logic [6:0] LINE_PAL       = 7'd63;
    localparam logic [6:0] LINE_NTSC      = 7'd65;
    localparam logic [8:0] FRAME_PAL      = 9'd312;
    localparam logic [8:0] FRAME_NTSC     = 9'd263;
    localparam logic [7:0] CTRL_BOOT      = 8'h1B;
    localparam logic [7:0] CTRL_BOOT_RSID = 8'h9B;
    localparam logic [7:0] CMP_BOOT_RSID  = 8'h37;
    localparam logic [8:0] BL_FIRST       = 9'h030;
    localparam logic [8:0] BL_LAST        = 9'h0F7;
    localparam logic [6:0] DMA_FIRST      = 7'd11;
    localparam logic [6:0] DMA_FULL       = 7'd14;
    localparam logic [6:0] DMA_LAST       = 7'd53;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        stall_t     stall;
        logic [8:0] line;
    } beam_res_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        action_t    act;
        logic [5:0] off;
        logic [7:0] data;    // config rows: bit 0 is the value
        logic       idx;     // config rows: register index
        logic       typed;   // expected result written into the row
        logic [7:0] rd;
        logic       irq;
        stall_t     stall;
        logic [8:0] line;
    } dir_row_t;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{ROW_REQ, ACT_READ,    OFF_CONTROL, 8'h00, CFG_NTSC, 1'b1, 8'h9B, 1'b0, STALL_NONE, 9'd311},
        '{ROW_REQ, ACT_READ,    OFF_RASTER,  8'h00, CFG_NTSC, 1'b1, 8'h37, 1'b0, STALL_NONE, 9'd311},
        '{ROW_REQ, ACT_READ,    OFF_STATUS,  8'h00, CFG_NTSC, 1'b1, 8'h01, 1'b0, STALL_NONE, 9'd311},
        '{ROW_REQ, ACT_WRITE,   6'h3F,       8'hFF, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd311},
        '{ROW_REQ, ACT_READ,    6'h3F,       8'h00, CFG_NTSC, 1'b1, 8'hFF, 1'b0, STALL_NONE, 9'd311},
        // end of frame wraps to line 0
        '{ROW_REQ, ACT_TICK,    6'h00,       8'hFF, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd0},
        // enabling re-fires the flag left pending by reset
        '{ROW_REQ, ACT_WRITE,   OFF_ENABLE,  8'h01, CFG_NTSC, 1'b1, 8'h00, 1'b1, STALL_NONE, 9'd0},
        // no source left, so bit 7 drops with the acknowledge
        '{ROW_REQ, ACT_WRITE,   OFF_STATUS,  8'h01, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd0},
        // line 0 compares as the beam leaves cycle 0, not as it enters it
        '{ROW_REQ, ACT_TICK,    6'h00,       8'h00, CFG_NTSC, 1'b1, 8'h00, 1'b1, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_WRITE,   OFF_STATUS,  8'hFF, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_READ,    OFF_STATUS,  8'hFF, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_WRITE,   OFF_ENABLE,  8'h00, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_CFG, ACT_TICK,    6'h00,       8'h01, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_RESTART, 6'h00,       8'h00, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd262},
        '{ROW_REQ, ACT_READ,    OFF_CONTROL, 8'h00, CFG_NTSC, 1'b1, 8'h9B, 1'b0, STALL_NONE, 9'd262},
        // cycle counter past the new PAL limit wraps on the next advance
        '{ROW_CFG, ACT_TICK,    6'h00,       8'h00, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_TICK,    6'h00,       8'h00, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd263},
        '{ROW_CFG, ACT_TICK,    6'h00,       8'h01, CFG_RSID, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_RESTART, 6'h3F,       8'hFF, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd311},
        '{ROW_REQ, ACT_READ,    OFF_STATUS,  8'h00, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        // line 311 is beyond the NTSC frame: wraps to 0 at the next line advance
        '{ROW_CFG, ACT_TICK,    6'h00,       8'h01, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_TICK,    6'h00,       8'h00, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_TICK,    6'h00,       8'h00, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_TICK,    6'h00,       8'h00, CFG_NTSC, 1'b1, 8'h00, 1'b0, STALL_NONE, 9'd0},
        '{ROW_REQ, ACT_WRITE,   6'h00,       8'h00, CFG_NTSC, 1'b0, 8'h00, 1'b0, STALL_NONE, 9'd0},
        // restarts leave the plain bytes alone
        '{ROW_REQ, ACT_READ,    6'h3F,       8'h00, CFG_NTSC, 1'b1, 8'hFF, 1'b0, STALL_NONE, 9'd0}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = ACT_TICK;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = CFG_NTSC;
    logic        cfg_wdata = 1'b0;

    // predictor state
    logic       geo_ntsc;
    logic       boot_rsid;
    logic [6:0] beam_x;
    logic [8:0] beam_y;
    logic [7:0] ctrl_shadow;
    logic [7:0] cmp_shadow;
    logic [7:0] irq_stat;
    logic [7:0] irq_mask;
    logic [7:0] slot_bytes [0:63];

    beam_res_t raster_due [$];

    int tx_gap_max  = 11;
    int rx_gap_max  = 11;
    int req_count   = 0;
    int res_count   = 0;
    int err_count   = 0;
    int irq_seen    = 0;
    int read_stalls = 0;
    int full_stalls = 0;

    raster_timing_irq_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [6:0] line_cycles();
        return geo_ntsc ? LINE_NTSC : LINE_PAL;
    endfunction

    function automatic logic [8:0] frame_lines();
        return geo_ntsc ? FRAME_NTSC : FRAME_PAL;
    endfunction

    task automatic beam_restart();
        beam_x      = line_cycles() - 7'd1;
        beam_y      = frame_lines() - 9'd1;
        irq_stat    = 8'h01;
        irq_mask    = 8'h00;
        ctrl_shadow = boot_rsid ? CTRL_BOOT_RSID : CTRL_BOOT;
        cmp_shadow  = boot_rsid ? CMP_BOOT_RSID : 8'h00;
    endtask

    task automatic raster_compare_check();
        if (beam_y == {ctrl_shadow[7], cmp_shadow})
        begin
            irq_stat[0] = 1'b1;
            if (irq_mask[0])
                irq_stat[7] = 1'b1;
        end
    endtask

    task automatic beam_advance();
        if (beam_x == 7'd0 && beam_y == 9'd0)
            raster_compare_check();
        beam_x = beam_x + 7'd1;
        // >= rather than == so a geometry change mid-line still wraps
        if (beam_x >= line_cycles())
        begin
            beam_x = 7'd0;
            beam_y = beam_y + 9'd1;
            if (beam_y >= frame_lines())
                beam_y = 9'd0;
            if (beam_y != 9'd0)
                raster_compare_check();
        end
    endtask

    function automatic stall_t stall_now();
        if (ctrl_shadow[4] && beam_y >= BL_FIRST && beam_y <= BL_LAST &&
            ctrl_shadow[2:0] == beam_y[2:0] && beam_x >= DMA_FIRST && beam_x <= DMA_LAST)
            return (beam_x >= DMA_FULL) ? STALL_FULL : STALL_READ;
        return STALL_NONE;
    endfunction

    task automatic predict_raster_step(input action_t act, input logic [5:0] off,
                                       input logic [7:0] data, output beam_res_t res);
        logic [7:0] rd;
        logic [7:0] s;
        rd = 8'h00;
        case (act)
            ACT_TICK:
                beam_advance();
            ACT_WRITE:
            begin
                if (off == OFF_CONTROL)
                    ctrl_shadow = data;
                else if (off == OFF_RASTER)
                    cmp_shadow = data;
                else if (off == OFF_STATUS)
                begin
                    s = irq_stat & ~data;
                    if (s[3:0] == 4'h0)
                        s[7] = 1'b0;
                    irq_stat = s;
                end
                else if (off == OFF_ENABLE)
                begin
                    irq_mask = data;
                    if (data[0] && irq_stat[0])
                        irq_stat[7] = 1'b1;
                end
                else
                    slot_bytes[off] = data;
            end
            ACT_READ:
            begin
                if (off == OFF_CONTROL)
                    rd = {beam_y[8], ctrl_shadow[6:0]};
                else if (off == OFF_RASTER)
                    rd = beam_y[7:0];
                else if (off == OFF_STATUS)
                    rd = irq_stat;
                else if (off == OFF_ENABLE)
                    rd = irq_mask;
                else
                    rd = slot_bytes[off];
            end
            default:
                beam_restart();
        endcase
        res.rd    = rd;
        res.irq   = irq_stat[7];
        res.stall = stall_now();
        res.line  = beam_y;
    endtask

    // offer one request; returns at the edge that takes it, tvalid left high
    task automatic send_req(input action_t act, input logic [5:0] off, input logic [7:0] data,
                            input logic typed, input beam_res_t typed_res);
        int gap;
        beam_res_t res;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, data, off};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_raster_step(act, off, data, res);
        raster_due.push_back(typed ? typed_res : res);
        req_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (raster_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic val);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NTSC)
            geo_ntsc = val;
        else
            boot_rsid = val;
    endtask

    function automatic logic [5:0] pick_special();
        case ($urandom_range(0, 3))
            0:       return OFF_CONTROL;
            1:       return OFF_RASTER;
            2:       return OFF_STATUS;
            default: return OFF_ENABLE;
        endcase
    endfunction

    // short register sequences dropped into the tick stream during a sweep
    task automatic reg_burst();
        logic [8:0] tgt;
        logic [7:0] val;
        logic [5:0] off;
        int         step;
        val = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:
                send_req(ACT_READ, pick_special(), val, 1'b0, '0);
            1:
            begin
                // arm the compare on the beam's line or up to two lines ahead of it
                step = $urandom_range(0, 2);
                tgt  = beam_y + 9'(step);
                if (tgt >= frame_lines())
                    tgt = tgt - frame_lines();
                val[7] = tgt[8];
                val[4] = ($urandom_range(0, 3) != 0);
                send_req(ACT_WRITE, OFF_CONTROL, val, 1'b0, '0);
                send_req(ACT_WRITE, OFF_RASTER, tgt[7:0], 1'b0, '0);
            end
            2:
            begin
                val[0] = ($urandom_range(0, 3) != 0);
                send_req(ACT_WRITE, OFF_ENABLE, val, 1'b0, '0);
            end
            3:
            begin
                case ($urandom_range(0, 4))
                    0: val = 8'h01;
                    1: val = 8'h80;
                    2: val = 8'h81;
                    3: val = 8'hFF;
                    default: ;
                endcase
                send_req(ACT_WRITE, OFF_STATUS, val, 1'b0, '0);
            end
            4:
            begin
                off = 6'($urandom_range(0, 63));
                send_req(ACT_WRITE, off, val, 1'b0, '0);
                send_req(ACT_READ, off, 8'h00, 1'b0, '0);
            end
            default:
                send_req(ACT_WRITE, OFF_CONTROL, val, 1'b0, '0);
        endcase
    endtask

    task automatic sweep_frame(input int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                reg_burst();
            else
                send_req(ACT_TICK, 6'h00, 8'h00, 1'b0, '0);
        end
    endtask

    task automatic random_req();
        int         pick;
        action_t    act;
        logic [5:0] off;
        logic [7:0] data;
        if ($urandom_range(0, 99) == 0)
            drain();
        pick = $urandom_range(0, 19);
        if (pick < 11)
            act = ACT_TICK;
        else if (pick < 15)
            act = ACT_WRITE;
        else if (pick < 19)
            act = ACT_READ;
        else
            act = ACT_RESTART;
        off = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 4) < 3)
            off = pick_special();
        data = 8'($urandom_range(0, 255));
        if (act == ACT_WRITE && $urandom_range(0, 1) == 1)
        begin
            if (off == OFF_RASTER)
                data = beam_y[7:0] + 8'd1;
            else if (off == OFF_STATUS)
                data = $urandom_range(0, 1) ? 8'h01 : 8'h80;
            else if (off == OFF_ENABLE)
                data[0] = 1'b1;
        end
        send_req(act, off, data, 1'b0, '0);
    endtask

    initial
    begin : rx_side
        int        gap;
        beam_res_t got;
        beam_res_t want;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            // long hold-offs let the block fill and push back on requests
            if (res_count == HOLD_AT_A || res_count == HOLD_AT_B)
                gap = HOLD_LEN;
            else
                gap = $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got.rd    = m_tdata[7:0];
            got.irq   = m_tdata[8];
            got.stall = stall_t'(m_tdata[10:9]);
            got.line  = m_tdata[19:11];
            res_count++;
            irq_seen    += got.irq;
            read_stalls += (got.stall == STALL_READ);
            full_stalls += (got.stall == STALL_FULL);
            if (raster_due.size() == 0)
            begin
                $display("%0t: result %h arrived with nothing expected", $time, m_tdata);
                err_count++;
            end
            else
            begin
                want = raster_due.pop_front();
                if (got.rd != want.rd)
                begin
                    $display("%0t: read_data exp %h got %h", $time, want.rd, got.rd);
                    err_count++;
                end
                if (got.irq != want.irq)
                begin
                    $display("%0t: irq_line exp %0d got %0d", $time, want.irq, got.irq);
                    err_count++;
                end
                if (got.stall != want.stall)
                begin
                    $display("%0t: cpu_stall exp %0d got %0d", $time, want.stall, got.stall);
                    err_count++;
                end
                if (got.line != want.line)
                begin
                    $display("%0t: raster_line exp %0d got %0d", $time, want.line, got.line);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cyc++;
        end
        $display("timeout after %0d cycles, %0d results still due", cyc, raster_due.size());
        $display("[raster_timing_irq_unit] ERROR");
        $finish;
    end

    initial
    begin : stim
        beam_res_t typed_res;
        geo_ntsc  = 1'b0;
        boot_rsid = 1'b0;
        for (int i = 0; i < 64; i++)
            slot_bytes[i] = 8'h00;
        beam_restart();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].kind == ROW_CFG)
                write_cfg(dir_tab[i].idx, dir_tab[i].data[0]);
            else
            begin
                typed_res = '{dir_tab[i].rd, dir_tab[i].irq, dir_tab[i].stall, dir_tab[i].line};
                send_req(dir_tab[i].act, dir_tab[i].off, dir_tab[i].data, dir_tab[i].typed,
                         typed_res);
            end
        end

        // back-to-back sweeps: the first PAL lines, then the first NTSC lines
        tx_gap_max = 0;
        rx_gap_max = 0;
        write_cfg(CFG_NTSC, 1'b0);
        write_cfg(CFG_RSID, 1'b0);
        send_req(ACT_RESTART, 6'h00, 8'h00, 1'b0, '0);
        sweep_frame(SWEEP_PAL);
        write_cfg(CFG_NTSC, 1'b1);
        write_cfg(CFG_RSID, 1'b1);
        send_req(ACT_RESTART, 6'h00, 8'h00, 1'b0, '0);
        sweep_frame(SWEEP_NTSC);

        tx_gap_max = 11;
        rx_gap_max = 11;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_cfg(CFG_NTSC, ph[0]);
            write_cfg(CFG_RSID, ph[1]);
            for (int n = 0; n < RAND_PHASE; n++)
                random_req();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("run: %0d requests over a directed table, PAL and NTSC sweeps, four random phases",
                 req_count);
        $display("%0d results, %0d mismatches; irq high %0d, read/full stalls %0d/%0d",
                 res_count, err_count, irq_seen, read_stalls, full_stalls);
        if (err_count == 0)
            $display("[raster_timing_irq_unit] OK");
        else
            $display("[raster_timing_irq_unit] ERROR");
        $finish;
    end

endmodule
